// ===== rtl/core/lksa_pkg.sv =====
package lksa_pkg;

  localparam int NUM_SERVERS_DEF = 64;
  localparam int TIME_W          = 32;
  localparam int WANT_W          = 7;
  localparam int DUR_W           = 16;
  localparam int SUM_W           = 12;
  localparam int ACTIVE_W        = 7;
  localparam int BUSY_W          = 33;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;
  localparam logic [SUM_W-1:0]    SUM_MAX      = 12'hFFF;

  typedef struct packed {
    logic [TIME_W-1:0] request_time;
    logic [WANT_W-1:0] servers_wanted;
    logic [DUR_W-1:0]  duration;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [SUM_W-1:0] id_sum;
  } res_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic alloc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic enough;
    logic alloc_done;
  } sts_t;

endpackage

// ===== rtl/core/lksa_ctrl.sv =====
module lksa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          cfg_ready,
  output logic          out_valid,
  input  logic          out_stall,
  input  lksa_pkg::sts_t sts,
  output lksa_pkg::cmd_t cmd
);
  import lksa_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_ALLOC  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = sts.enough ? S_ALLOC : S_DONE;
      end
      S_ALLOC: begin
        if (sts.alloc_done) begin
          state_next = S_DONE;
        end else begin
          cmd.alloc = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

endmodule

// ===== rtl/core/lksa_dp.sv =====
module lksa_dp #(
  parameter int NUM_SERVERS = lksa_pkg::NUM_SERVERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lksa_pkg::cmd_t                  cmd,
  input  lksa_pkg::req_t                  req,
  input  logic                            cfg_we,
  input  logic [lksa_pkg::ACTIVE_W-1:0]   cfg_data,
  output lksa_pkg::sts_t                  sts,
  output lksa_pkg::res_t                  res
);
  import lksa_pkg::*;

  localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int CW = $clog2(NUM_SERVERS + 1);

  logic [ACTIVE_W-1:0]    active;
  logic [TIME_W-1:0]      t;
  logic [WANT_W-1:0]      want;
  logic [WANT_W-1:0]      left;
  logic [BUSY_W-1:0]      busy_end;
  logic [CW-1:0]          n;
  logic [CW-1:0]          idx;
  logic [CW-1:0]          cnt;
  logic                   pend;
  logic [IW-1:0]          pend_idx;
  logic [NUM_SERVERS-1:0] free_vec;
  logic [SUM_W-1:0]       sum;
  logic                   granted;

  logic [BUSY_W-1:0]      mem [NUM_SERVERS];
  logic [NUM_SERVERS-1:0] vld;
  logic [BUSY_W-1:0]      rd_data;
  logic                   rd_vld;

  logic [CW-1:0]          n_next;
  logic                   in_range;
  logic                   rd_en;
  logic                   wr_en;
  logic                   is_free;
  logic [BUSY_W-1:0]      entry;
  logic [SUM_W:0]         sum_add;
  logic [SUM_W-1:0]       sum_next;

  always_comb begin
    if (32'(active) > 32'(NUM_SERVERS)) begin
      n_next = CW'(NUM_SERVERS);
    end else begin
      n_next = CW'(active);
    end
  end

  assign in_range = (idx < n);
  assign rd_en    = cmd.scan && in_range;
  assign wr_en    = cmd.alloc && (left != '0) && in_range && free_vec[idx[IW-1:0]];
  assign entry    = rd_vld ? rd_data : '0;
  assign is_free  = (entry <= {1'b0, t});
  assign sum_add  = {1'b0, sum} + (SUM_W+1)'(idx) + (SUM_W+1)'(1);
  assign sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[idx[IW-1:0]];
      rd_vld  <= vld[idx[IW-1:0]];
    end
    if (wr_en) begin
      mem[idx[IW-1:0]] <= busy_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      active <= ACTIVE_RESET;
      pend   <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[idx[IW-1:0]] <= 1'b1;
      end
      if (cfg_we) begin
        active <= cfg_data;
      end
      if (cmd.load) begin
        pend <= 1'b0;
      end else if (cmd.scan) begin
        pend <= in_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t        <= req.request_time;
      want     <= req.servers_wanted;
      busy_end <= {1'b0, req.request_time} + BUSY_W'(req.duration);
      n        <= n_next;
      idx      <= '0;
      cnt      <= '0;
    end
    if (cmd.scan) begin
      if (in_range) begin
        pend_idx <= idx[IW-1:0];
        idx      <= idx + CW'(1);
      end
      if (pend) begin
        free_vec[pend_idx] <= is_free;
        if (is_free) begin
          cnt <= cnt + CW'(1);
        end
      end
    end
    if (cmd.decide) begin
      granted <= sts.enough;
      sum     <= '0;
      left    <= want;
      idx     <= '0;
    end
    if (cmd.alloc && (left != '0) && in_range) begin
      if (free_vec[idx[IW-1:0]]) begin
        sum  <= sum_next;
        left <= left - WANT_W'(1);
      end
      idx <= idx + CW'(1);
    end
    if (cmd.out_load) begin
      res.granted <= granted;
      res.id_sum  <= sum;
    end
  end

  assign sts.scan_done  = !in_range && !pend;
  assign sts.enough     = (32'(cnt) >= 32'(want));
  assign sts.alloc_done = (left == '0) || !in_range;

endmodule

// ===== rtl/core/lowest_k_server_allocator_top.sv =====
// channel | direction | handshake          | payload
// cfg     | in        | cfg_valid/ready    | cfg_data (active servers)
// in      | in        | in_valid/in_stall  | in_data  (lksa_pkg::req_t)
// out     | out       | out_valid/out_stall| out_data (lksa_pkg::res_t)
//
// One request at a time: the busy-until memory is scanned through its single
// registered read port, a decision follows, then allocation (skipped on a
// refusal), then the result is loaded; the scan covers the first n servers,
// where n is the active server count, capped at NUM_SERVERS.
// Synchronous active-high reset clears all servers to free and active to 64.
// A stalled result waits in the output register while the next request runs.
module lowest_k_server_allocator_top #(
  parameter int NUM_SERVERS = lksa_pkg::NUM_SERVERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lksa_pkg::ACTIVE_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lksa_pkg::req_t                in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lksa_pkg::res_t                out_data
);
  import lksa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  lksa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lksa_dp #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .sts      (sts),
    .res      (out_data)
  );

endmodule

// ===== rtl/core/lksa_chk.sv =====
module lksa_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [lksa_pkg::ACTIVE_W-1:0] cfg_data,
  input logic                          in_valid,
  input logic                          in_stall,
  input lksa_pkg::req_t                in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input lksa_pkg::res_t                out_data
);
  import lksa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request beat not followed by busy");

  a_refuse_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.granted |-> out_data.id_sum == '0)
    else $error("refused result carries a nonzero sum");

  a_cfg_only_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !in_stall)
    else $error("configuration offered while a request is in progress");

endmodule

bind lowest_k_server_allocator_top lksa_chk u_chk (.*);

// ===== test/tb_lowest_k_server_allocator_top.sv =====
`timescale 1ns / 100ps

module tb_lowest_k_server_allocator_top;
  import lksa_pkg::*;

  localparam int NUM_SRV     = NUM_SERVERS_DEF;
  localparam int SETTLE      = 4;
  localparam int TAIL_CYCLES = 2 * NUM_SRV + 20;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2000000;

  typedef enum logic [1:0] {
    FEED_REQ,
    FEED_CFG,
    FEED_DRAIN
  } feed_kind_t;

  typedef struct {
    feed_kind_t            kind;
    req_t                  req;
    logic [ACTIVE_W-1:0]   active;
  } feed_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ACTIVE_W-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  req_t                in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  res_t                out_data;

  feed_t               feed_q[$];
  res_t                grant_q[$];
  logic [BUSY_W-1:0]   busy_till[NUM_SRV];
  logic [ACTIVE_W-1:0] active_cfg = ACTIVE_RESET;
  logic [TIME_W-1:0]   clock_now  = '0;

  int quiet       = 0;
  int reqs_seen   = 0;
  int errors      = 0;
  int granted_cnt = 0;
  int refused_cnt = 0;
  int cfg_writes  = 0;
  int cycles      = 0;
  int burst_left  = 1;
  int gap_left    = 0;
  int hold_left   = 0;
  int holds_done  = 0;
  int stall_mode  = 0;
  int mode_left   = 0;
  logic toggle    = 1'b0;
  logic feed_idle = 1'b0;

  lowest_k_server_allocator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic res_t allocate_lowest(req_t r);
    int unsigned       span;
    int unsigned       free_cnt;
    int unsigned       left;
    int unsigned       sum;
    logic [BUSY_W-1:0] now;
    logic [BUSY_W-1:0] till;
    res_t              res;
    span     = (active_cfg > NUM_SRV) ? NUM_SRV : active_cfg;
    now      = {1'b0, r.request_time};
    free_cnt = 0;
    res      = '0;
    for (int s = 0; s < span; s++) begin
      if (busy_till[s] <= now) free_cnt++;
    end
    if (free_cnt >= r.servers_wanted) begin
      till = now + {{(BUSY_W-DUR_W){1'b0}}, r.duration};
      left = r.servers_wanted;
      sum  = 0;
      for (int s = 0; s < span && left > 0; s++) begin
        if (busy_till[s] <= now) begin
          busy_till[s] = till;
          sum += s + 1;
          left--;
        end
      end
      res.granted = 1'b1;
      res.id_sum  = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic queue_request(logic [TIME_W-1:0] t, logic [WANT_W-1:0] w,
                               logic [DUR_W-1:0] d);
    feed_t f;
    f.kind   = FEED_REQ;
    f.req    = '{request_time: t, servers_wanted: w, duration: d};
    f.active = '0;
    feed_q   = {feed_q, f};
  endtask

  task automatic queue_setting(logic [ACTIVE_W-1:0] act);
    feed_t f;
    f.kind   = FEED_DRAIN;
    f.req    = '0;
    f.active = '0;
    feed_q   = {feed_q, f};
    f.kind   = FEED_CFG;
    f.active = act;
    feed_q   = {feed_q, f};
  endtask

  task automatic queue_phase(int count, logic [ACTIVE_W-1:0] act);
    int                unsigned span;
    int                pick;
    logic [TIME_W-1:0] t;
    logic [WANT_W-1:0] w;
    logic [DUR_W-1:0]  d;
    queue_setting(act);
    span = (act > NUM_SRV) ? NUM_SRV : act;
    if (span == 0) span = 1;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick >= 85) clock_now += $urandom_range(21, 400);
      else if (pick >= 30) clock_now += $urandom_range(1, 20);
      t = clock_now;
      if ($urandom_range(0, 49) == 0) t = clock_now - $urandom_range(1, 50);
      pick = $urandom_range(0, 99);
      if (pick < 60) w = WANT_W'($urandom_range(1, (span + 3) / 4));
      else if (pick < 75) w = WANT_W'($urandom_range(1, span));
      else if (pick < 85) w = WANT_W'(span + $urandom_range(0, 1));
      else if (pick < 92) w = '0;
      else w = WANT_W'($urandom_range(0, 127));
      pick = $urandom_range(0, 99);
      if (pick < 75) d = DUR_W'($urandom_range(1, 60));
      else if (pick < 92) d = DUR_W'($urandom_range(61, 600));
      else if (pick < 99) d = DUR_W'($urandom_range(0, 1));
      else d = DUR_W'($urandom_range(0, 65535));
      queue_request(t, w, d);
    end
  endtask

  // driver
  always @(posedge clk) begin : feed_driver
    logic                nv_in_valid;
    logic                nv_cfg_valid;
    req_t                nv_in_data;
    logic [ACTIVE_W-1:0] nv_cfg_data;
    feed_t               head;
    nv_in_valid  = in_valid;
    nv_cfg_valid = cfg_valid;
    nv_in_data   = in_data;
    nv_cfg_data  = cfg_data;
    if (rst) begin
      nv_in_valid  = 1'b0;
      nv_cfg_valid = 1'b0;
    end else if (!(in_valid && in_stall) && !(cfg_valid && !cfg_ready)) begin
      nv_in_valid  = 1'b0;
      nv_cfg_valid = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (feed_q.size() != 0) begin
        head = feed_q[0];
        case (head.kind)
          FEED_REQ: begin
            nv_in_valid = 1'b1;
            nv_in_data  = head.req;
            void'(feed_q.pop_front());
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 40);
              case ($urandom_range(0, 4))
                0, 1: gap_left = 0;
                2, 3: gap_left = $urandom_range(1, 4);
                default: gap_left = $urandom_range(5, 30);
              endcase
            end else begin
              burst_left--;
            end
          end
          FEED_DRAIN: begin
            if (!in_valid && !cfg_valid && quiet >= 1) void'(feed_q.pop_front());
          end
          FEED_CFG: begin
            if (!in_valid && !cfg_valid && quiet >= SETTLE) begin
              nv_cfg_valid = 1'b1;
              nv_cfg_data  = head.active;
              void'(feed_q.pop_front());
            end
          end
          default: ;
        endcase
      end
    end
    in_valid  <= nv_in_valid;
    in_data   <= nv_in_data;
    cfg_valid <= nv_cfg_valid;
    cfg_data  <= nv_cfg_data;
    feed_idle <= (feed_q.size() == 0) && !nv_in_valid && !nv_cfg_valid;
  end

  // monitor and predictor
  always @(posedge clk) begin : grant_monitor
    res_t want_res;
    res_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (grant_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat: granted=%0b id_sum=%0d",
                                    got.granted, got.id_sum));
        end else begin
          want_res = grant_q.pop_front();
          if (got.granted !== want_res.granted || got.id_sum !== want_res.id_sum)
            report_mismatch($sformatf(
              "mismatch: expected granted=%0b id_sum=%0d, got granted=%0b id_sum=%0d",
              want_res.granted, want_res.id_sum, got.granted, got.id_sum));
          if (want_res.granted) granted_cnt++;
          else refused_cnt++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        active_cfg = cfg_data;
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        grant_q = {grant_q, allocate_lowest(in_data)};
        reqs_seen <= reqs_seen + 1;
      end
      quiet <= (grant_q.size() != 0) ? 0 : ((quiet < 1000) ? quiet + 1 : quiet);
    end
  end

  // long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin : holdoff
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && reqs_seen >= 400 + 600 * holds_done) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin : stall_pattern
    logic s;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: s = 1'b0;
      1: s = ($urandom_range(0, 3) == 0);
      2: s = ($urandom_range(0, 3) != 0);
      default: begin
        toggle = ~toggle;
        s      = toggle;
      end
    endcase
    out_stall <= (hold_left != 0) || s;
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("lowest_k_server_allocator_top verification failed");
      $finish;
    end
  end

  initial begin : run
    logic [ACTIVE_W-1:0] settings[11];
    for (int s = 0; s < NUM_SRV; s++) busy_till[s] = '0;

    // release at t comes before a request at t
    queue_request(32'd0, 7'd1, 16'd5);
    queue_request(32'd0, 7'd64, 16'd1);
    queue_request(32'd0, 7'd0, 16'd7);
    queue_request(32'd3, 7'd2, 16'd4);
    queue_request(32'd5, 7'd63, 16'd10);
    queue_request(32'd5, 7'd62, 16'd10);
    queue_request(32'd7, 7'd2, 16'd1);
    queue_request(32'd8, 7'd64, 16'd0);
    queue_request(32'd4, 7'd1, 16'd1);
    queue_request(32'd15, 7'd64, 16'd0);
    queue_request(32'd15, 7'd127, 16'd1);
    queue_request(32'd15, 7'd64, 16'hFFFF);
    queue_request(32'd100, 7'd1, 16'd1);
    queue_request(32'd65550, 7'd32, 16'd3);
    queue_request(32'd65550, 7'd33, 16'd2);
    queue_setting(7'd0);
    queue_request(32'd70000, 7'd1, 16'd1);
    queue_request(32'd70000, 7'd0, 16'd1);
    queue_setting(7'd127);
    queue_request(32'd70000, 7'd64, 16'd1);
    queue_request(32'd70001, 7'd65, 16'd1);
    queue_setting(7'd1);
    queue_request(32'd70002, 7'd1, 16'd9);
    queue_request(32'd70002, 7'd1, 16'd9);
    queue_setting(7'd64);
    queue_request(32'd70005, 7'd64, 16'd1);
    queue_request(32'd70005, 7'd63, 16'd1);
    clock_now = 32'd70005;

    settings = '{7'd8, 7'd1, 7'd0, 7'd127, 7'd3, 7'd65, 7'd16, 7'd32,
                 7'($urandom_range(1, 64)), 7'($urandom_range(0, 127)), 7'd64};
    foreach (settings[p]) begin
      clock_now += $urandom_range(70000, 1 << 24);
      queue_phase((settings[p] == 0) ? 30 : 130, settings[p]);
    end

    // top of the time range, then allocations whose end time needs the extra bit
    clock_now = 32'hF000_0000 + $urandom_range(0, 32'h0F00_0000);
    queue_phase(40, 7'd64);
    queue_setting(7'd64);
    queue_request(32'hFFFF_FFFF, 7'd64, 16'hFFFF);
    queue_request(32'hFFFF_FFFF, 7'd1, 16'd1);
    queue_request(32'hFFFF_FFFF, 7'd0, 16'hFFFF);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!(feed_idle && quiet >= TAIL_CYCLES));
    @(negedge clk);

    $display("%0d requests checked (%0d granted, %0d refused) over %0d active-server settings",
             granted_cnt + refused_cnt, granted_cnt, refused_cnt, cfg_writes);
    $display("%0d mismatches in %0d cycles", errors, cycles);
    if (errors == 0) begin
      $display("lowest_k_server_allocator_top verification clean");
    end else begin
      $display("lowest_k_server_allocator_top verification failed");
    end
    $finish;
  end

endmodule
